/* hw/rtl/clri_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package clri_pkg;

    localparam int CHAN_BITS          = 8;
    localparam int COLOR_BITS         = 3 * CHAN_BITS;
    localparam int COUNT_BITS         = 5;
    localparam int INDEX_BITS         = 4;
    localparam int IN_POS_BITS        = 16;
    localparam int MAX_POINTS_DEF     = 16;
    localparam int POSITION_BITS_DEF  = 16;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

endpackage

`default_nettype wire

/* hw/rtl/clri_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module clri_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/clri_blend.sv */
`timescale 1ns / 1ps
`default_nettype none

module clri_blend #(
    parameter int POS_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [clri_pkg::CHAN_BITS-1:0] i_a,
    input  wire logic [clri_pkg::CHAN_BITS-1:0] i_b,
    input  wire logic [POS_BITS-1:0]           i_d,
    input  wire logic [POS_BITS-1:0]           i_o,
    output logic                               o_done,
    output logic      [clri_pkg::CHAN_BITS-1:0] o_q
);

    import clri_pkg::*;

    localparam int ACC_W  = POS_BITS + CHAN_BITS;
    localparam int STEP_W = $clog2(CHAN_BITS);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_MUL0 = 4'b0010,
        B_MUL1 = 4'b0100,
        B_DIV  = 4'b1000
    } t_bstate;

    t_bstate              r_state, n_state;
    logic [CHAN_BITS-1:0] r_a, r_b;
    logic [POS_BITS-1:0]  r_d, r_dmo, r_o;
    logic [ACC_W-1:0]     r_acc;
    logic [STEP_W-1:0]    r_step;
    logic                 r_done;
    logic [CHAN_BITS-1:0] r_q;

    logic [ACC_W-1:0]     w_mx, w_my, w_prod, w_dsh;
    logic                 w_ge;

    // one multiplier shared by both products
    assign w_mx   = (r_state == B_MUL0) ? ACC_W'(r_a) : ACC_W'(r_b);
    assign w_my   = (r_state == B_MUL0) ? ACC_W'(r_dmo) : ACC_W'(r_o);
    assign w_prod = w_mx * w_my;

    // restoring division, one quotient bit per cycle
    assign w_dsh  = ACC_W'(r_d) << r_step;
    assign w_ge   = (r_acc >= w_dsh);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_start && (i_d != '0)) begin
                    n_state = B_MUL0;
                end
            end
            B_MUL0: n_state = B_MUL1;
            B_MUL1: n_state = B_DIV;
            B_DIV: begin
                if (r_step == '0) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= ((r_state == B_IDLE) && i_start && (i_d == '0))
                    || ((r_state == B_DIV) && (r_step == '0));
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                if (i_start) begin
                    r_a    <= i_a;
                    r_b    <= i_b;
                    r_d    <= i_d;
                    r_o    <= i_o;
                    r_dmo  <= i_d - i_o;
                    r_step <= STEP_W'(CHAN_BITS - 1);
                    // zero span gives the start color
                    r_q    <= i_a;
                end
            end
            B_MUL0: r_acc <= w_prod;
            B_MUL1: r_acc <= r_acc + w_prod;
            B_DIV: begin
                if (w_ge) begin
                    r_acc <= r_acc - w_dsh;
                end
                r_q    <= {r_q[CHAN_BITS-2:0], w_ge};
                r_step <= r_step - 1'b1;
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

`default_nettype wire

/* hw/rtl/color_ramp_interpolator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Piecewise linear color ramp. A write transfer (op 0) stores one control point
// (position and RGB) in a table slot; writes to slots at or above MAX_POINTS
// are dropped. A lookup transfer (op 1) scans adjacent point pairs in table
// order, one pair per cycle through the single table read port, and
// interpolates the first pair whose span holds the position, ends inclusive,
// giving found=1; with no match the result is black with found=0. The three
// channels go one after another through one shared multiply and restoring
// divide unit, and after a lookup the block accepts nothing else until its
// result has been taken.
module color_ramp_interpolator #(
    parameter int MAX_POINTS    = clri_pkg::MAX_POINTS_DEF,
    parameter int POSITION_BITS = clri_pkg::POSITION_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [clri_pkg::COUNT_BITS-1:0]  i_cfg_data,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic                             i_op,
    input  wire logic [clri_pkg::INDEX_BITS-1:0]  i_index,
    input  wire logic [clri_pkg::IN_POS_BITS-1:0] i_position,
    input  wire logic [clri_pkg::CHAN_BITS-1:0]   i_red_in,
    input  wire logic [clri_pkg::CHAN_BITS-1:0]   i_green_in,
    input  wire logic [clri_pkg::CHAN_BITS-1:0]   i_blue_in,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic      [clri_pkg::CHAN_BITS-1:0]   o_red_out,
    output logic      [clri_pkg::CHAN_BITS-1:0]   o_green_out,
    output logic      [clri_pkg::CHAN_BITS-1:0]   o_blue_out,
    output logic                                  o_found
);

    import clri_pkg::*;

    localparam int AW      = $clog2(MAX_POINTS);
    localparam int CW      = $clog2(MAX_POINTS + 1);
    localparam int ENTRY_W = POSITION_BITS + COLOR_BITS;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PRIME = 6'b000010,
        S_FIRST = 6'b000100,
        S_SCAN  = 6'b001000,
        S_WAIT  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state                   r_state, n_state;
    logic [COUNT_BITS-1:0]    r_point_count;
    logic [POSITION_BITS-1:0] r_pos, r_d, r_o;
    logic [CW-1:0]            r_n;
    logic [AW-1:0]            r_k, r_rd_addr;
    logic [ENTRY_W-1:0]       r_prev;
    logic [COLOR_BITS-1:0]    r_c0, r_c1;
    logic                     r_start;
    logic [1:0]               r_ch;
    logic [CHAN_BITS-1:0]     r_red, r_green, r_blue;
    logic                     r_found;

    logic                     w_accept, w_wr;
    logic [POSITION_BITS-1:0] w_in_pos, w_p0, w_p1;
    logic [CW-1:0]            w_n_lim;
    logic [ENTRY_W-1:0]       w_rdata;
    logic                     w_match, w_last;
    logic [CHAN_BITS-1:0]     w_a, w_b, w_q;
    logic                     w_done;

    assign w_accept = i_valid && o_ready;
    assign w_in_pos = POSITION_BITS'(i_position);
    assign w_wr     = w_accept && (i_op == OP_WRITE) && (32'(i_index) < MAX_POINTS);
    assign w_n_lim  = (32'(r_point_count) > MAX_POINTS) ? CW'(MAX_POINTS)
                                                        : CW'(r_point_count);

    clri_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (AW'(i_index)),
        .i_wdata ({w_in_pos, i_red_in, i_green_in, i_blue_in}),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rdata)
    );

    assign w_p0    = r_prev[ENTRY_W-1 -: POSITION_BITS];
    assign w_p1    = w_rdata[ENTRY_W-1 -: POSITION_BITS];
    assign w_match = (r_pos >= w_p0) && (r_pos <= w_p1);
    assign w_last  = (32'(r_k) + 1 >= 32'(r_n));

    // channel select: red, green, blue
    always_comb begin
        unique case (r_ch)
            2'd0: begin
                w_a = r_c0[3*CHAN_BITS-1 -: CHAN_BITS];
                w_b = r_c1[3*CHAN_BITS-1 -: CHAN_BITS];
            end
            2'd1: begin
                w_a = r_c0[2*CHAN_BITS-1 -: CHAN_BITS];
                w_b = r_c1[2*CHAN_BITS-1 -: CHAN_BITS];
            end
            default: begin
                w_a = r_c0[CHAN_BITS-1:0];
                w_b = r_c1[CHAN_BITS-1:0];
            end
        endcase
    end

    clri_blend #(
        .POS_BITS (POSITION_BITS)
    ) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_d     (r_d),
        .i_o     (r_o),
        .o_done  (w_done),
        .o_q     (w_q)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_op == OP_LOOKUP)) begin
                    n_state = (32'(w_n_lim) < 2) ? S_OUT : S_PRIME;
                end
            end
            S_PRIME: n_state = S_FIRST;
            S_FIRST: n_state = S_SCAN;
            S_SCAN: begin
                if (w_match) begin
                    n_state = S_WAIT;
                end else if (w_last) begin
                    n_state = S_OUT;
                end
            end
            S_WAIT: begin
                if (w_done && (r_ch == 2'd2)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_point_count <= '0;
            r_start       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_point_count <= i_cfg_data;
            end
            r_start <= ((r_state == S_SCAN) && w_match)
                    || ((r_state == S_WAIT) && w_done && (r_ch != 2'd2));
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_pos     <= w_in_pos;
                r_n       <= w_n_lim;
                r_rd_addr <= '0;
                r_k       <= AW'(1);
                r_red     <= '0;
                r_green   <= '0;
                r_blue    <= '0;
                r_found   <= 1'b0;
            end
            S_PRIME: r_rd_addr <= r_rd_addr + 1'b1;
            S_FIRST: begin
                r_prev    <= w_rdata;
                r_rd_addr <= r_rd_addr + 1'b1;
            end
            S_SCAN: begin
                if (w_match) begin
                    r_d     <= w_p1 - w_p0;
                    r_o     <= r_pos - w_p0;
                    r_c0    <= r_prev[COLOR_BITS-1:0];
                    r_c1    <= w_rdata[COLOR_BITS-1:0];
                    r_ch    <= 2'd0;
                    r_found <= 1'b1;
                end else begin
                    r_prev    <= w_rdata;
                    r_k       <= r_k + 1'b1;
                    r_rd_addr <= r_rd_addr + 1'b1;
                end
            end
            S_WAIT: begin
                if (w_done) begin
                    unique case (r_ch)
                        2'd0:    r_red   <= w_q;
                        2'd1:    r_green <= w_q;
                        default: r_blue  <= w_q;
                    endcase
                    r_ch <= r_ch + 1'b1;
                end
            end
            S_OUT: ;
            default: ;
        endcase
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_red_out   = r_red;
    assign o_green_out = r_green;
    assign o_blue_out  = r_blue;
    assign o_found     = r_found;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while a result is pending");

    a_start_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> (r_state == S_WAIT))
        else $error("blend start outside channel sequencing");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_WAIT) && !r_start)
        else $error("blend done while not waiting");

    a_miss_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |->
            (o_red_out == '0) && (o_green_out == '0) && (o_blue_out == '0))
        else $error("unmatched lookup not black");

endmodule

`default_nettype wire

/* tb/tb_color_ramp_interpolator.sv */
`timescale 1ns / 1ps

module tb_color_ramp_interpolator;
    import clri_pkg::*;

    localparam int NPTS        = MAX_POINTS_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int IDLE_TAIL   = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int MIXED_ITEMS = 37;

    typedef struct {
        logic                   op;
        logic [INDEX_BITS-1:0]  index;
        logic [IN_POS_BITS-1:0] position;
        logic [CHAN_BITS-1:0]   red;
        logic [CHAN_BITS-1:0]   green;
        logic [CHAN_BITS-1:0]   blue;
    } t_ramp_req;

    typedef struct {
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
        logic                 found;
    } t_ramp_color;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_cfg_we   = 1'b0;
    logic [COUNT_BITS-1:0]  i_cfg_data = '0;
    logic                   i_valid    = 1'b0;
    logic                   o_ready;
    logic                   i_op       = OP_WRITE;
    logic [INDEX_BITS-1:0]  i_index    = '0;
    logic [IN_POS_BITS-1:0] i_position = '0;
    logic [CHAN_BITS-1:0]   i_red_in   = '0;
    logic [CHAN_BITS-1:0]   i_green_in = '0;
    logic [CHAN_BITS-1:0]   i_blue_in  = '0;
    logic                   o_valid;
    logic                   i_ready    = 1'b0;
    logic [CHAN_BITS-1:0]   o_red_out;
    logic [CHAN_BITS-1:0]   o_green_out;
    logic [CHAN_BITS-1:0]   o_blue_out;
    logic                   o_found;

    color_ramp_interpolator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_index     (i_index),
        .i_position  (i_position),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_found     (o_found)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor copy of the table and the point count
    logic [IN_POS_BITS-1:0] ramp_pos [NPTS];
    logic [COLOR_BITS-1:0]  ramp_rgb [NPTS];
    logic [COUNT_BITS-1:0]  points_in_use = '0;

    t_ramp_req   ramp_pending_q [$];
    t_ramp_color ramp_expect_q [$];
    t_ramp_color chk_want;

    int dir_pos [NPTS] = '{
        0, 0, 1000, 5000, 5001, 20000, 40000, 30000,
        45000, 50000, 52000, 55000, 60000, 62000, 64000, 65535
    };
    logic [COLOR_BITS-1:0] dir_rgb [NPTS] = '{
        24'h123456, 24'hFFFFFF, 24'h000000, 24'hFF0080,
        24'h00FF01, 24'h4D5863, 24'h0A141E, 24'hC86432,
        24'h010203, 24'hFFFFFF, 24'h000000, 24'h808080,
        24'hFF00FF, 24'h00FFFF, 24'h7F7F7F, 24'hFFFF00
    };
    int dir_probe [6] = '{0, 500, 1000, 35000, 42000, 65535};
    int phase_counts [8] = '{16, 31, 2, 5, 0, 1, 16, 9};

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  xfers_in       = 0;
    int  writes_seen    = 0;
    int  lookups_seen   = 0;
    int  results_seen   = 0;
    int  hits_seen      = 0;
    int  settings_done  = 0;
    logic in_taken      = 1'b0;
    logic drv_busy      = 1'b0;
    logic drv_next;
    t_ramp_req drv_item;
    int  burst_left     = 0;
    int  gap_left       = 0;
    int  rx_phase       = 0;
    logic [15:0] rx_mask = '1;
    logic hold_off      = 1'b0;

    function automatic logic [CHAN_BITS-1:0] mix_channel(
        input logic [CHAN_BITS-1:0]   a,
        input logic [CHAN_BITS-1:0]   b,
        input logic [IN_POS_BITS-1:0] span,
        input logic [IN_POS_BITS-1:0] ofs
    );
        logic [31:0] num;
        if (span == 0) begin
            return a;
        end
        num = 32'(a) * 32'(span - ofs) + 32'(b) * 32'(ofs);
        return 8'(num / 32'(span));
    endfunction

    function automatic t_ramp_color ramp_lookup(input logic [IN_POS_BITS-1:0] pos);
        t_ramp_color res;
        int n;
        logic [IN_POS_BITS-1:0] p0, p1;
        logic [COLOR_BITS-1:0] c0, c1;
        res.red   = '0;
        res.green = '0;
        res.blue  = '0;
        res.found = 1'b0;
        n = (points_in_use > NPTS) ? NPTS : int'(points_in_use);
        for (int k = 0; k + 1 < n; k++) begin
            p0 = ramp_pos[k];
            p1 = ramp_pos[k + 1];
            if (pos >= p0 && pos <= p1) begin
                c0 = ramp_rgb[k];
                c1 = ramp_rgb[k + 1];
                res.red   = mix_channel(c0[23:16], c1[23:16], p1 - p0, pos - p0);
                res.green = mix_channel(c0[15:8], c1[15:8], p1 - p0, pos - p0);
                res.blue  = mix_channel(c0[7:0], c1[7:0], p1 - p0, pos - p0);
                res.found = 1'b1;
                return res;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s, got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // result check first, then the input transfer of the same edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (ramp_expect_q.size() == 0) begin
                report_mismatch("result with no lookup pending", o_found, 0);
            end else begin
                chk_want = ramp_expect_q.pop_front();
                results_seen++;
                if (chk_want.found) begin
                    hits_seen++;
                end
                if (o_red_out !== chk_want.red) begin
                    report_mismatch("red_out", o_red_out, chk_want.red);
                end
                if (o_green_out !== chk_want.green) begin
                    report_mismatch("green_out", o_green_out, chk_want.green);
                end
                if (o_blue_out !== chk_want.blue) begin
                    report_mismatch("blue_out", o_blue_out, chk_want.blue);
                end
                if (o_found !== chk_want.found) begin
                    report_mismatch("found", o_found, chk_want.found);
                end
            end
        end
        in_taken = i_rst_n && i_valid && o_ready;
        if (in_taken) begin
            xfers_in++;
            if (i_op == OP_WRITE) begin
                ramp_pos[i_index] = i_position;
                ramp_rgb[i_index] = {i_red_in, i_green_in, i_blue_in};
                writes_seen++;
            end else begin
                ramp_expect_q = {ramp_expect_q, ramp_lookup(i_position)};
                lookups_seen++;
            end
        end
    end

    // sender: bursts of random length, random gaps between them
    always @(negedge i_clk) begin
        drv_next = drv_busy && !in_taken;
        if (i_rst_n && !drv_next) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (ramp_pending_q.size() > 0) begin
                drv_item = ramp_pending_q.pop_front();
                i_op       <= drv_item.op;
                i_index    <= drv_item.index;
                i_position <= drv_item.position;
                i_red_in   <= drv_item.red;
                i_green_in <= drv_item.green;
                i_blue_in  <= drv_item.blue;
                drv_next = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
        end
        drv_busy = drv_next;
        i_valid <= drv_next;
    end

    // receiver: stall pattern from a 16-bit mask, redrawn each time the mask index wraps
    always @(negedge i_clk) begin
        if (rx_phase == 0) begin
            case ($urandom_range(0, 3))
                0: rx_mask = '1;
                1: rx_mask = 16'($urandom);
                2: rx_mask = 16'($urandom) & 16'($urandom);
                default: rx_mask = 16'($urandom) | 16'($urandom);
            endcase
        end
        i_ready <= rx_mask[rx_phase] && !hold_off;
        rx_phase = (rx_phase + 1) % 16;
    end

    // long receiver hold-off while the sender still has items to offer
    initial begin
        while (!(xfers_in >= 150 && ramp_pending_q.size() > 10)) begin
            @(posedge i_clk);
        end
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("color_ramp_interpolator verification failed");
            $finish;
        end
    end

    task automatic queue_req(
        input logic            op,
        input int              idx,
        input int              pos,
        input logic [COLOR_BITS-1:0] rgb
    );
        t_ramp_req r;
        r.op       = op;
        r.index    = idx[INDEX_BITS-1:0];
        r.position = pos[IN_POS_BITS-1:0];
        r.red      = rgb[23:16];
        r.green    = rgb[15:8];
        r.blue     = rgb[7:0];
        ramp_pending_q = {ramp_pending_q, r};
    endtask

    task automatic wait_idle();
        while (ramp_pending_q.size() != 0 || drv_busy || ramp_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (IDLE_TAIL) @(posedge i_clk);
    endtask

    task automatic set_points(input int value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value[COUNT_BITS-1:0];
        points_in_use = value[COUNT_BITS-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_done++;
    endtask

    // ascending table with random spans, then mostly in-range lookups mixed with writes
    task automatic random_phase(input int count_value, input int n_mixed);
        int p;
        int pick;
        logic [IN_POS_BITS-1:0] gen_pos [NPTS];
        set_points(count_value);
        p = $urandom_range(0, 3000);
        for (int k = 0; k < NPTS; k++) begin
            if (k > 0 && $urandom_range(0, 5) != 0) begin
                p += $urandom_range(1, 7000);
            end
            if (p > 65535) begin
                p = 65535;
            end
            gen_pos[k] = p[IN_POS_BITS-1:0];
            queue_req(OP_WRITE, k, p, 24'($urandom));
        end
        for (int i = 0; i < n_mixed; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                queue_req(OP_WRITE, $urandom_range(0, NPTS - 1), $urandom, 24'($urandom));
            end else if (pick < 22) begin
                queue_req(OP_LOOKUP, $urandom, $urandom, 24'($urandom));
            end else if (pick < 35) begin
                queue_req(OP_LOOKUP, $urandom, gen_pos[$urandom_range(0, NPTS - 1)],
                          24'($urandom));
            end else begin
                queue_req(OP_LOOKUP, $urandom, $urandom_range(gen_pos[0], gen_pos[NPTS - 1]),
                          24'($urandom));
            end
        end
        wait_idle();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // no points in use after reset
        queue_req(OP_LOOKUP, 0, 0, 24'h000000);
        queue_req(OP_LOOKUP, NPTS - 1, 16'hFFFF, 24'hFFFFFF);
        // zero span at the start, descending pair in the middle
        for (int k = 0; k < NPTS; k++) begin
            queue_req(OP_WRITE, k, dir_pos[k], dir_rgb[k]);
        end
        wait_idle();

        set_points(NPTS);
        foreach (dir_probe[i]) begin
            queue_req(OP_LOOKUP, i, dir_probe[i], 24'($urandom));
        end
        wait_idle();

        set_points(2);
        queue_req(OP_LOOKUP, 0, 0, 24'($urandom));
        queue_req(OP_LOOKUP, 0, 1, 24'($urandom));
        wait_idle();

        set_points(1);
        queue_req(OP_LOOKUP, 0, 0, 24'($urandom));
        wait_idle();

        foreach (phase_counts[i]) begin
            random_phase(phase_counts[i], MIXED_ITEMS);
        end
        random_phase($urandom_range(0, 31), MIXED_ITEMS);

        $display("covered %0d table writes and %0d lookups (%0d in a segment, %0d misses)",
                 writes_seen, lookups_seen, hits_seen, results_seen - hits_seen);
        $display("across %0d point-count settings in %0d cycles, with a %0d-cycle output hold",
                 settings_done, cycle_count, HOLD_CYCLES);
        if (mismatch_count == 0) begin
            $display("color_ramp_interpolator verification clean");
        end else begin
            $display("color_ramp_interpolator verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/clri_pkg.sv
hw/rtl/clri_ram.sv
hw/rtl/clri_blend.sv
hw/rtl/color_ramp_interpolator.sv
tb/tb_color_ramp_interpolator.sv
